### design/two_axis_segment_move_planner_top_defines.svh
// Assertion macros used by the top-level design file.
`ifndef TWO_AXIS_SEGMENT_MOVE_PLANNER_TOP_DEFINES_SVH
`define TWO_AXIS_SEGMENT_MOVE_PLANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TASMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TASMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TASMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define TASMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### design/tasmp_pkg.sv
package tasmp_pkg;

    localparam int SENSOR_FULL = 1023;

    localparam int DIV_NW = 50;
    localparam int DIV_DW = 36;
    localparam int DIV_CW = 6;

    localparam logic [DIV_CW-1:0] NB_ZMAX = 6'd30;
    localparam logic [DIV_CW-1:0] NB_TGT  = 6'd30;
    localparam logic [DIV_CW-1:0] NB_FREQ = 6'd48;
    localparam logic [DIV_CW-1:0] NB_SF   = 6'd50;

    localparam logic [19:0] ZMAX_FLOOR = 20'd1000;
    localparam logic [15:0] FREQ_FLOOR = 16'd10;
    localparam logic [15:0] FREQ_SAT   = 16'hFFFF;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_SENSOR_MIN   = 3'd0;
    localparam logic [2:0] REG_SENSOR_MAX   = 3'd1;
    localparam logic [2:0] REG_REF_FREQ     = 3'd2;
    localparam logic [2:0] REG_Z_FULL_SCALE = 3'd3;
    localparam logic [2:0] REG_REF_RADIUS   = 3'd4;
    localparam logic [2:0] REG_MM_PER_COUNT = 3'd5;

    typedef struct packed {
        logic [9:0]  sensor_min;
        logic [9:0]  sensor_max;
        logic [15:0] ref_freq;
        logic [19:0] z_full_scale;
        logic [23:0] ref_radius;
        logic [23:0] mm_per_count;
    } cfg_t;

    typedef struct packed {
        logic               first_sample;
        logic               last_sample;
        logic [9:0]         sample_reading;
        logic signed [31:0] sample_target;
        logic signed [31:0] main_position;
        logic signed [31:0] second_position;
    } in_t;

    typedef struct packed {
        logic        move_valid;
        logic [31:0] main_pulses;
        logic        main_dir;
        logic [15:0] main_freq;
        logic [31:0] second_pulses;
        logic        second_dir;
        logic [15:0] second_freq;
        logic [15:0] segment_number;
        logic        weld_on;
        logic        finished;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_ZDIV,
        ST_ZWAIT,
        ST_ZMAX,
        ST_TPROD,
        ST_TDIV,
        ST_TWAIT,
        ST_ZTGT,
        ST_FDIV,
        ST_FWAIT,
        ST_FREQ,
        ST_SPROD,
        ST_SDIV,
        ST_SWAIT,
        ST_SFREQ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic zdiv;
        logic zmax;
        logic tprod;
        logic tdiv;
        logic ztgt;
        logic fdiv;
        logic freq;
        logic sprod;
        logic sdiv;
        logic sfreq;
        logic emit;
        logic move;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic playing;
        logic div_done;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

### design/tasmp_div.sv
module tasmp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tasmp_pkg::DIV_NW-1:0]  num,
    input  logic [tasmp_pkg::DIV_DW-1:0]  den,
    input  logic [tasmp_pkg::DIV_CW-1:0]  nbits,
    output logic [tasmp_pkg::DIV_NW-1:0]  quo,
    output logic                          busy,
    output logic                          done
);
    import tasmp_pkg::*;

    logic [DIV_NW-1:0] num_reg, num_next, quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next, den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DIV_DW:0]   rem_sh, rem_sub;
    logic              ge;

    always_comb begin
        rem_sh    = {rem_reg, num_reg[DIV_NW-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[DIV_NW-2:0], 1'b0};
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            rem_next = ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### design/tasmp_dp.sv
module tasmp_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  tasmp_pkg::cfg_t     cfg,
    input  tasmp_pkg::cmd_t     cmd,
    output tasmp_pkg::status_t  status,
    input  tasmp_pkg::in_t      s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tasmp_pkg::out_t     m_data
);
    import tasmp_pkg::*;

    in_t                item_reg;
    logic [9:0]         prev_reading_reg, prev_reading_next;
    logic [15:0]        seg_reg, seg_next;
    logic               playing_reg, playing_next, done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic [29:0]        zprod_reg;
    logic signed [32:0] dm_reg, ds_reg;
    logic [39:0]        fprod_reg;
    logic signed [35:0] rprod_reg;
    logic signed [36:0] radius_reg;
    logic [19:0]        zmax_reg;
    logic [29:0]        tprod_reg;
    logic [32:0]        mp_reg, sp_reg;
    logic [15:0]        mf_reg, sf_reg;
    logic [48:0]        sprod_reg;

    logic signed [10:0] d_prev;
    logic [9:0]         span, r_off;
    logic [19:0]        zmax_c, ztgt_c;
    logic [15:0]        mf_c, sf_c;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num, div_quo;
    logic [DIV_DW-1:0]  div_den;
    logic [DIV_CW-1:0]  div_nb;
    logic               div_busy, div_done;

    assign d_prev = $signed({1'b0, prev_reading_reg}) - $signed({1'b0, cfg.sensor_min});
    assign span   = cfg.sensor_max - cfg.sensor_min;
    assign r_off  = item_reg.sample_reading - cfg.sensor_min;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_nb    = NB_ZMAX;
        if (cmd.zdiv) begin
            div_start = 1'b1;
            div_num   = {zprod_reg, 20'b0};
            div_den   = DIV_DW'(SENSOR_FULL);
            div_nb    = NB_ZMAX;
        end else if (cmd.tdiv) begin
            div_start = 1'b1;
            div_num   = {tprod_reg, 20'b0};
            div_den   = {26'b0, span};
            div_nb    = NB_TGT;
        end else if (cmd.fdiv) begin
            div_start = 1'b1;
            div_num   = {fprod_reg, 10'b0};
            div_den   = radius_reg[35:0];
            div_nb    = NB_FREQ;
        end else if (cmd.sdiv) begin
            div_start = 1'b1;
            div_num   = {sprod_reg, 1'b0} + {17'b0, mp_reg};
            div_den   = {2'b0, mp_reg, 1'b0};
            div_nb    = NB_SF;
        end
    end

    tasmp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .nbits   (div_nb),
        .quo     (div_quo),
        .busy    (div_busy),
        .done    (div_done)
    );

    always_comb begin
        if (cfg.sensor_max <= cfg.sensor_min) begin
            zmax_c = cfg.z_full_scale;
        end else begin
            zmax_c = (div_quo[29:0] > {10'b0, cfg.z_full_scale}) ? cfg.z_full_scale
                                                               : div_quo[19:0];
            if (zmax_c < ZMAX_FLOOR) begin
                zmax_c = ZMAX_FLOOR;
            end
        end

        if (item_reg.sample_reading <= cfg.sensor_min) begin
            ztgt_c = '0;
        end else if (item_reg.sample_reading >= cfg.sensor_max) begin
            ztgt_c = zmax_reg;
        end else begin
            ztgt_c = div_quo[19:0];
        end

        if (radius_reg[36] || radius_reg == '0) begin
            mf_c = FREQ_SAT;
        end else if (div_quo[DIV_NW-1:16] != '0) begin
            mf_c = FREQ_SAT;
        end else if (div_quo[15:0] < FREQ_FLOOR) begin
            mf_c = FREQ_FLOOR;
        end else begin
            mf_c = div_quo[15:0];
        end

        if (mp_reg == '0 || sp_reg == '0) begin
            sf_c = '0;
        end else if (div_quo[DIV_NW-1:16] != '0) begin
            sf_c = FREQ_SAT;
        end else if (div_quo[15:0] == '0) begin
            sf_c = 16'd1;
        end else begin
            sf_c = div_quo[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.prep) begin
            zprod_reg <= span * cfg.z_full_scale;
            dm_reg    <= 33'(item_reg.sample_target) - 33'(item_reg.main_position);
            fprod_reg <= cfg.ref_radius * cfg.ref_freq;
            rprod_reg <= d_prev * $signed({1'b0, cfg.mm_per_count});
        end
        if (cmd.zdiv) begin
            radius_reg <= $signed({5'b0, cfg.ref_radius, 8'b0}) + 37'(rprod_reg);
        end
        if (cmd.zmax) begin
            zmax_reg <= zmax_c;
        end
        if (cmd.tprod) begin
            tprod_reg <= r_off * zmax_reg;
        end
        if (cmd.ztgt) begin
            ds_reg <= $signed({13'b0, ztgt_c}) - 33'(item_reg.second_position);
        end
        if (cmd.fdiv) begin
            mp_reg <= dm_reg[32] ? 33'(-dm_reg) : 33'(dm_reg);
            sp_reg <= ds_reg[32] ? 33'(-ds_reg) : 33'(ds_reg);
        end
        if (cmd.freq) begin
            mf_reg <= mf_c;
        end
        if (cmd.sprod) begin
            sprod_reg <= sp_reg * mf_reg;
        end
        if (cmd.sfreq) begin
            sf_reg <= sf_c;
        end
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        prev_reading_next = prev_reading_reg;
        seg_next          = seg_reg;
        playing_next      = playing_reg;
        done_next         = done_reg;
        if (cmd.move) begin
            seg_next          = seg_reg + 16'd1;
            prev_reading_next = item_reg.sample_reading;
            if (item_reg.last_sample) begin
                playing_next = 1'b0;
                done_next    = 1'b1;
            end
        end else if (item_reg.first_sample) begin
            seg_next          = '0;
            prev_reading_next = item_reg.sample_reading;
            done_next         = item_reg.last_sample;
            playing_next      = !item_reg.last_sample;
        end

        out_next = '0;
        out_next.weld_on  = playing_next;
        out_next.finished = done_next;
        if (cmd.move) begin
            out_next.move_valid     = 1'b1;
            out_next.main_pulses    = mp_reg[31:0];
            out_next.main_dir       = !(!dm_reg[32] && dm_reg != '0);
            out_next.main_freq      = mf_reg;
            out_next.second_pulses  = sp_reg[31:0];
            out_next.second_dir     = !(!ds_reg[32] && ds_reg != '0);
            out_next.second_freq    = sf_reg;
            out_next.segment_number = seg_reg;
        end else begin
            out_next.segment_number = seg_next;
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reading_reg <= '0;
            seg_reg          <= '0;
            playing_reg      <= 1'b0;
            done_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.emit) begin
                prev_reading_reg <= prev_reading_next;
                seg_reg          <= seg_next;
                playing_reg      <= playing_next;
                done_reg         <= done_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.first    = item_reg.first_sample;
    assign status.playing  = playing_reg;
    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### design/tasmp_ctrl.sv
module tasmp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tasmp_pkg::status_t  status,
    output tasmp_pkg::cmd_t     cmd
);
    import tasmp_pkg::*;

    state_t state_reg, state_next;
    logic   move_reg, move_next;

    always_comb begin
        state_next = state_reg;
        move_next  = move_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                move_next  = !status.first && status.playing;
                state_next = (!status.first && status.playing) ? ST_PREP : ST_EMIT;
            end
            ST_PREP:  state_next = ST_ZDIV;
            ST_ZDIV:  state_next = ST_ZWAIT;
            ST_ZWAIT: begin
                if (status.div_done) begin
                    state_next = ST_ZMAX;
                end
            end
            ST_ZMAX:  state_next = ST_TPROD;
            ST_TPROD: state_next = ST_TDIV;
            ST_TDIV:  state_next = ST_TWAIT;
            ST_TWAIT: begin
                if (status.div_done) begin
                    state_next = ST_ZTGT;
                end
            end
            ST_ZTGT:  state_next = ST_FDIV;
            ST_FDIV:  state_next = ST_FWAIT;
            ST_FWAIT: begin
                if (status.div_done) begin
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:  state_next = ST_SPROD;
            ST_SPROD: state_next = ST_SDIV;
            ST_SDIV:  state_next = ST_SWAIT;
            ST_SWAIT: begin
                if (status.div_done) begin
                    state_next = ST_SFREQ;
                end
            end
            ST_SFREQ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP:  cmd.prep  = 1'b1;
            ST_ZDIV:  cmd.zdiv  = 1'b1;
            ST_ZMAX:  cmd.zmax  = 1'b1;
            ST_TPROD: cmd.tprod = 1'b1;
            ST_TDIV:  cmd.tdiv  = 1'b1;
            ST_ZTGT:  cmd.ztgt  = 1'b1;
            ST_FDIV:  cmd.fdiv  = 1'b1;
            ST_FREQ:  cmd.freq  = 1'b1;
            ST_SPROD: cmd.sprod = 1'b1;
            ST_SDIV:  cmd.sdiv  = 1'b1;
            ST_SFREQ: cmd.sfreq = 1'b1;
            ST_EMIT: begin
                cmd.emit = status.out_free;
                cmd.move = move_reg;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            move_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            move_reg  <= move_next;
        end
    end

endmodule

### design/two_axis_segment_move_planner_top.sv
// Two-axis segment move planner.
// Input channel s_valid/s_ready/s_data carries one recorded sample per word,
// with the current positions of both axes. Output channel m_valid/m_ready/
// m_data returns exactly one result word per sample, in order.
// A sample that closes a segment has its result word computed by four
// divisions on the shared radix-2 divider (second axis scale, second axis
// target, main frequency, second frequency) between control states. Any
// other sample skips the divisions and goes straight to its result word.
// One sample is worked on at a time; the next one is taken as soon as the
// previous result is written to the output register, even if that result
// is still waiting. When the receiver stalls, the result word holds and the
// block finishes the next sample, then waits until the output register
// frees up. Reset (aresetn low, synchronous) clears playback state and the
// segment index and loads the default configuration. Configuration
// registers sit on the APB port at byte address 4*index and are to be
// written only while idle, by the user; the block itself does not enforce this.
`include "two_axis_segment_move_planner_top_defines.svh"

module two_axis_segment_move_planner_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tasmp_pkg::in_t               s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tasmp_pkg::out_t              m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tasmp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tasmp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    cmd_t       ctrl_cmd;
    status_t    dp_status;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SENSOR_MIN:   cfg_next.sensor_min   = pwdata[9:0];
                REG_SENSOR_MAX:   cfg_next.sensor_max   = pwdata[9:0];
                REG_REF_FREQ:     cfg_next.ref_freq     = pwdata[15:0];
                REG_Z_FULL_SCALE: cfg_next.z_full_scale = pwdata[19:0];
                REG_REF_RADIUS:   cfg_next.ref_radius   = pwdata[23:0];
                REG_MM_PER_COUNT: cfg_next.mm_per_count = pwdata[23:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SENSOR_MIN:   prdata = {22'b0, cfg_reg.sensor_min};
            REG_SENSOR_MAX:   prdata = {22'b0, cfg_reg.sensor_max};
            REG_REF_FREQ:     prdata = {16'b0, cfg_reg.ref_freq};
            REG_Z_FULL_SCALE: prdata = {12'b0, cfg_reg.z_full_scale};
            REG_REF_RADIUS:   prdata = {8'b0, cfg_reg.ref_radius};
            REG_MM_PER_COUNT: prdata = {8'b0, cfg_reg.mm_per_count};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_min   <= 10'd0;
            cfg_reg.sensor_max   <= 10'd1023;
            cfg_reg.ref_freq     <= 16'd1000;
            cfg_reg.z_full_scale <= 20'd160000;
            cfg_reg.ref_radius   <= 24'd128000;
            cfg_reg.mm_per_count <= 24'd65536;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tasmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    tasmp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (ctrl_cmd),
        .status  (dp_status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `TASMP_ASSERT_IMPLY(a_no_accept_in_div, aclk, aresetn, dp_status.div_busy, !s_ready)
    `TASMP_ASSERT_IMPLY(a_idle_word_zero, aclk, aresetn, m_valid && !m_data.move_valid, m_data.main_pulses == 32'd0 && m_data.second_freq == 16'd0)
    `TASMP_ASSERT_IMPLY(a_weld_xor_done, aclk, aresetn, m_valid, !(m_data.weld_on && m_data.finished))
    `TASMP_ASSERT_NEXT(a_emit_shows, aclk, aresetn, ctrl_cmd.emit, m_valid)

endmodule

### verif/move_plan_checker.sv
`timescale 1ns / 100ps

module move_plan_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  tasmp_pkg::in_t   s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  tasmp_pkg::out_t  m_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [tasmp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output int               fail_count,
    output int               pending_moves
);
    import tasmp_pkg::*;

    cfg_t cfg;
    logic [9:0] last_reading;
    logic [15:0] seg_idx;
    logic playing_q, done_q;
    out_t planned_moves[$];

    assign pending_moves = planned_moves.size();

    function automatic longint zmax_of();
        longint zm;
        if (cfg.sensor_max <= cfg.sensor_min) return longint'(cfg.z_full_scale);
        zm = longint'(cfg.sensor_max - cfg.sensor_min) * longint'(cfg.z_full_scale)
            / SENSOR_FULL;
        if (zm > longint'(cfg.z_full_scale)) zm = cfg.z_full_scale;
        if (zm < 1000) zm = 1000;
        return zm;
    endfunction

    function automatic longint second_goal(logic [9:0] rd);
        longint zm;
        if (rd <= cfg.sensor_min) return 0;
        zm = zmax_of();
        if (rd >= cfg.sensor_max) return zm;
        return longint'(rd - cfg.sensor_min) * zm / longint'(cfg.sensor_max - cfg.sensor_min);
    endfunction

    function automatic longint main_rate(logic [9:0] rd);
        longint d, rad, q;
        d = longint'(rd) - longint'(cfg.sensor_min);
        rad = longint'(cfg.ref_radius) * 256 + d * longint'(cfg.mm_per_count);
        if (rad <= 0) return 65535;
        q = longint'(cfg.ref_radius) * 256 * longint'(cfg.ref_freq) / rad;
        if (q < 10) q = 10;
        if (q > 65535) q = 65535;
        return q;
    endfunction

    function automatic out_t plan_move(in_t w);
        out_t r;
        longint dm, ds, mp, sp, mf, sf;
        r = '0;
        if (w.first_sample) begin
            seg_idx = 0;
            last_reading = w.sample_reading;
            done_q = w.last_sample;
            playing_q = !w.last_sample;
        end else if (playing_q) begin
            dm = longint'(w.sample_target) - longint'(w.main_position);
            ds = second_goal(w.sample_reading) - longint'(w.second_position);
            mp = dm < 0 ? -dm : dm;
            sp = ds < 0 ? -ds : ds;
            mf = main_rate(last_reading);
            sf = 0;
            if (mp > 0 && sp > 0) begin
                sf = (2 * sp * mf + mp) / (2 * mp);
                if (sf < 1) sf = 1;
                if (sf > 65535) sf = 65535;
            end
            r.move_valid = 1'b1;
            r.main_pulses = mp[31:0];
            r.main_dir = !(dm > 0);
            r.main_freq = mf[15:0];
            r.second_pulses = sp[31:0];
            r.second_dir = !(ds > 0);
            r.second_freq = sf[15:0];
            r.segment_number = seg_idx;
            seg_idx = seg_idx + 16'd1;
            last_reading = w.sample_reading;
            if (w.last_sample) begin
                playing_q = 1'b0;
                done_q = 1'b1;
            end
            r.weld_on = playing_q;
            r.finished = done_q;
            return r;
        end
        r.segment_number = seg_idx;
        r.weld_on = playing_q;
        r.finished = done_q;
        return r;
    endfunction

    task automatic compare_field(string nm, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d actual %0d", nm, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_t e;
        if (!aresetn) begin
            cfg <= '{10'd0, 10'd1023, 16'd1000, 20'd160000, 24'd128000, 24'd65536};
            last_reading = 0;
            seg_idx = 0;
            playing_q = 0;
            done_q = 0;
            fail_count = 0;
            planned_moves.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_SENSOR_MIN:   cfg.sensor_min <= pwdata[9:0];
                    REG_SENSOR_MAX:   cfg.sensor_max <= pwdata[9:0];
                    REG_REF_FREQ:     cfg.ref_freq <= pwdata[15:0];
                    REG_Z_FULL_SCALE: cfg.z_full_scale <= pwdata[19:0];
                    REG_REF_RADIUS:   cfg.ref_radius <= pwdata[23:0];
                    REG_MM_PER_COUNT: cfg.mm_per_count <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) planned_moves.push_back(plan_move(s_data));
            if (m_valid && m_ready) begin
                if (planned_moves.size() == 0) begin
                    $error("result word with no expectation");
                    fail_count++;
                end else begin
                    e = planned_moves.pop_front();
                    compare_field("move_valid", e.move_valid, m_data.move_valid);
                    compare_field("main_pulses", e.main_pulses, m_data.main_pulses);
                    compare_field("main_dir", e.main_dir, m_data.main_dir);
                    compare_field("main_freq", e.main_freq, m_data.main_freq);
                    compare_field("second_pulses", e.second_pulses, m_data.second_pulses);
                    compare_field("second_dir", e.second_dir, m_data.second_dir);
                    compare_field("second_freq", e.second_freq, m_data.second_freq);
                    compare_field("segment_number", e.segment_number,
                        m_data.segment_number);
                    compare_field("weld_on", e.weld_on, m_data.weld_on);
                    compare_field("finished", e.finished, m_data.finished);
                end
            end
        end
    end
endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tasmp_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    in_t s_data = '0;
    logic m_valid, m_ready = 0;
    out_t m_data;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    int fail_count, pending_moves;
    bit calm_phase = 0;
    int quiet_cycles = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    two_axis_segment_move_planner_top i_dut (.*);

    move_plan_checker i_checker (.*);

    always @(posedge aclk) begin
        m_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'(idx) << 2; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (pending_moves != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_sample(bit fs, bit ls, logic [9:0] rd, int tg, int mp, int sp);
        in_t w;
        if (!calm_phase) begin
            while ($urandom_range(99) < 10) begin
                s_valid <= 0;
                @(posedge aclk);
            end
        end
        w.first_sample = fs;
        w.last_sample = ls;
        w.sample_reading = rd;
        w.sample_target = tg;
        w.main_position = mp;
        w.second_position = sp;
        s_data <= w;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_input();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic random_cfg(int mode);
        logic [9:0] lo, hi;
        lo = $urandom_range(1023);
        hi = $urandom_range(1023);
        if (mode == 0 && lo > hi) begin
            lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
        end
        write_reg(REG_SENSOR_MIN, {$urandom} & 32'hFFFF_FC00 | lo);
        write_reg(REG_SENSOR_MAX, hi);
        write_reg(REG_REF_FREQ, $urandom_range(65535));
        write_reg(REG_Z_FULL_SCALE, $urandom_range(1048575, 1000));
        write_reg(REG_REF_RADIUS, $urandom_range(16777215, 1));
        write_reg(REG_MM_PER_COUNT, $urandom_range(16777215));
    endtask

    function automatic int rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            default: return $urandom_range(400000) - 200000;
        endcase
    endfunction

    initial begin
        int n, seg_len;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        calm_phase = 1;
        send_sample(0, 0, 10'd5, 1, 0, 0);
        send_sample(1, 1, 10'd0, 0, 0, 0);
        send_sample(1, 0, 10'd0, 0, 0, 0);
        send_sample(0, 0, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_sample(0, 0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(0, 0, 10'd512, 100, 100, 0);
        send_sample(0, 0, 10'd512, 100, 50, 80000);
        send_sample(0, 1, 10'd1023, -5, 5, 3);
        send_sample(0, 0, 10'd300, 9, 0, 0);
        idle_input();
        drain();

        write_reg(REG_SENSOR_MIN, 10'd1023);
        write_reg(REG_SENSOR_MAX, 10'd0);
        write_reg(REG_REF_FREQ, 16'hFFFF);
        write_reg(REG_Z_FULL_SCALE, 20'hFFFFF);
        write_reg(REG_REF_RADIUS, 24'd1);
        write_reg(REG_MM_PER_COUNT, 24'hFFFFFF);
        send_sample(1, 0, 10'd0, 0, 0, 0);
        send_sample(0, 0, 10'd1023, 7, 0, 0);
        send_sample(0, 0, 10'd10, 70000, 0, 1);
        send_sample(0, 1, 10'd1023, 1, 0, 5);
        idle_input();
        drain();

        write_reg(REG_SENSOR_MIN, 10'd0);
        write_reg(REG_SENSOR_MAX, 10'd1);
        write_reg(REG_REF_FREQ, 16'd0);
        write_reg(REG_Z_FULL_SCALE, 20'd1000);
        write_reg(REG_REF_RADIUS, 24'hFFFFFF);
        write_reg(REG_MM_PER_COUNT, 24'd0);
        send_sample(1, 0, 10'd1, 0, 0, 0);
        send_sample(0, 0, 10'd0, 3, 0, 0);
        send_sample(0, 1, 10'd1, 100000, 0, 0);
        idle_input();
        drain();

        n = 0;
        for (int phase = 0; phase < 6; phase++) begin
            random_cfg(phase % 3);
            calm_phase = (phase == 2);
            while (n < 140 * (phase + 1)) begin
                if ($urandom_range(9) == 0) begin
                    send_sample($urandom_range(1), $urandom_range(1),
                        $urandom_range(1023), rand_pos(), rand_pos(), rand_pos());
                    n++;
                end else begin
                    seg_len = $urandom_range(12, 1);
                    send_sample(1, 0, $urandom_range(1023), rand_pos(), rand_pos(), rand_pos());
                    for (int k = 0; k < seg_len; k++)
                        send_sample(0, k == seg_len - 1, $urandom_range(1023),
                            rand_pos(), rand_pos(), rand_pos());
                    n += seg_len + 1;
                end
                if ($urandom_range(30) == 0) begin
                    idle_input();
                    while (pending_moves != 0) @(posedge aclk);
                end
            end
            idle_input();
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
